>>> design/gps_pkg.sv
`timescale 1ns / 1ps
package gps_pkg;

  localparam int CELL_W = 10;
  localparam int CMD_W = 2;
  localparam int STAT_W = 2;
  localparam int CNT_W = 11;
  localparam int DIM_W = 9;
  localparam int CMP_W = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int REG_DIM_W = 6;

  localparam logic [CMD_W-1:0] CMD_WALL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

  localparam logic [STAT_W-1:0] ST_SEARCH = 2'd0;
  localparam logic [STAT_W-1:0] ST_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FAILED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd4;

  localparam logic MODE_BFS = 1'b0;
  localparam logic MODE_DFS = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [CMP_W-1:0]  n;
    logic [CELL_W-1:0] start;
    logic [CELL_W-1:0] goal;
    logic              mode;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CELL_W-1:0] cell_index;
    logic              wall_bit;
    logic [CELL_W-1:0] path_position;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_res;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  visited_total;
    logic [CNT_W-1:0]  path_cells;
    logic              duplicate_skip;
  } res_t;

endpackage

>>> design/gps_in_if.sv
`timescale 1ns / 1ps
interface gps_in_if import gps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CELL_W-1:0] cell_index;
  logic              wall_bit;
  logic [CELL_W-1:0] path_position;

  modport source (output valid, command, cell_index, wall_bit, path_position, input ready);
  modport sink (input valid, command, cell_index, wall_bit, path_position, output ready);
endinterface

>>> design/gps_out_if.sv
`timescale 1ns / 1ps
interface gps_out_if import gps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_res;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  visited_total;
  logic [CNT_W-1:0]  path_cells;
  logic              duplicate_skip;

  modport source (output valid, cell_res, status, visited_total, path_cells, duplicate_skip,
                  input ready);
  modport sink (input valid, cell_res, status, visited_total, path_cells, duplicate_skip,
                output ready);
endinterface

>>> design/gps_cfg_if.sv
`timescale 1ns / 1ps
interface gps_cfg_if import gps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/gps_ram.sv
`timescale 1ns / 1ps
module gps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/gps_rem.sv
`timescale 1ns / 1ps
module gps_rem import gps_pkg::*; #(
  parameter int AW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             done,
  output logic [DIM_W-1:0] rem
);

  localparam int CW = $clog2(AW + 1);

  logic [AW-1:0]  shreg;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [DIM_W:0] trial;

  // one quotient bit per cycle, remainder only
  assign trial = {rem, shreg[AW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg <= dividend;
        rem <= '0;
        cnt <= CW'(AW);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= DIM_W'(trial - {1'b0, divisor});
        end else begin
          rem <= DIM_W'(trial);
        end
        shreg <= shreg << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/gps_seq.sv
`timescale 1ns / 1ps
module gps_seq import gps_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLUMNS = 32,
  parameter int LIST_DEPTH = 4100
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  accept,
  output logic  idle,
  output logic  res_valid,
  input  logic  res_take,
  output res_t  res
);

  localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW = $clog2(LIST_DEPTH + 1);
  localparam int LAW = $clog2(LIST_DEPTH);
  localparam int PW = $clog2(CELLS + 1);
  localparam int CMW = AW + 2;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_SEED, S_POPW, S_DFSV, S_EVAL, S_DIV,
    S_NRD, S_NCHK, S_TRD, S_TCHK, S_PW, S_DONE
  } state_t;

  state_t             state;
  logic [AW-1:0]      idx;
  logic [LW-1:0]      head, tail;
  logic [AW-1:0]      cur, nx;
  logic [CNT_W-1:0]   visit;
  logic [PW-1:0]      ptotal, tlen;
  logic [STAT_W-1:0]  status;
  logic               dup;
  logic [CELL_W-1:0]  res_cell;
  logic [1:0]         slot_cnt;
  logic [3:0]         exist;

  logic               wall_we, wall_wdata, wall_rdata;
  logic [AW-1:0]      wall_waddr, wall_raddr;
  logic               cm_we;
  logic [AW-1:0]      cm_waddr, cm_raddr;
  logic [CMW-1:0]     cm_wdata, cm_rdata;
  logic               ls_we;
  logic [LAW-1:0]     ls_waddr, ls_raddr;
  logic [AW-1:0]      ls_wdata, ls_rdata;
  logic               pt_we;
  logic [AW-1:0]      pt_waddr, pt_raddr, pt_wdata, pt_rdata;

  logic               rem_start, rem_done;
  logic [DIM_W-1:0]   rem;
  logic [1:0]         slot;
  logic [AW-1:0]      nb_addr;
  logic               start_ok, nb_take, trace_end;
  logic [CMP_W-1:0]   cur_w;

  gps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
    .clk, .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
    .raddr(wall_raddr), .rdata(wall_rdata));

  // {visited, no parent, parent}
  gps_ram #(.WIDTH(CMW), .DEPTH(CELLS)) u_cellm (
    .clk, .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .raddr(cm_raddr), .rdata(cm_rdata));

  gps_ram #(.WIDTH(AW), .DEPTH(LIST_DEPTH)) u_list (
    .clk, .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(ls_raddr), .rdata(ls_rdata));

  // path kept goal first; reads index from the far end
  gps_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_path (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata));

  gps_rem #(.AW(AW)) u_rem (
    .clk, .rst, .start(rem_start), .dividend(cur), .divisor(cfg.cols),
    .done(rem_done), .rem);

  assign cur_w = CMP_W'(cur);
  assign start_ok = CMP_W'(cfg.start) < cfg.n;
  assign slot = (cfg.mode == MODE_DFS) ? ~slot_cnt : slot_cnt;
  assign nb_take = (CMP_W'(nx) < cfg.n) && !wall_rdata && !cm_rdata[CMW-1];
  assign trace_end = (cur_w == CMP_W'(cfg.start)) || (CMP_W'(tlen) + CMP_W'(1) >= CMP_W'(CELLS))
                     || cm_rdata[AW] || (cm_rdata[AW-1:0] == cur);

  always_comb begin
    unique case (slot)
      2'd0:    nb_addr = AW'(cur_w - CMP_W'(cfg.cols));
      2'd1:    nb_addr = AW'(cur_w + CMP_W'(cfg.cols));
      2'd2:    nb_addr = cur - AW'(1);
      default: nb_addr = cur + AW'(1);
    endcase
  end

  always_comb begin
    wall_we = 1'b0;
    wall_waddr = idx;
    wall_wdata = 1'b0;
    wall_raddr = nb_addr;
    cm_we = 1'b0;
    cm_waddr = cur;
    cm_wdata = '0;
    cm_raddr = cur;
    ls_we = 1'b0;
    ls_waddr = LAW'(tail);
    ls_wdata = nx;
    ls_raddr = (cfg.mode == MODE_DFS) ? LAW'(tail - LW'(1)) : LAW'(head);
    pt_we = 1'b0;
    pt_waddr = AW'(tlen);
    pt_wdata = cur;
    pt_raddr = AW'(CMP_W'(ptotal) - CMP_W'(1) - CMP_W'(item.path_position));
    rem_start = 1'b0;
    unique case (state)
      S_INIT: begin
        wall_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && item.command == CMD_WALL && CMP_W'(item.cell_index) < CMP_W'(CELLS)) begin
          wall_we = 1'b1;
          wall_waddr = AW'(item.cell_index);
          wall_wdata = item.wall_bit;
        end
      end
      S_CLR: begin
        cm_we = 1'b1;
        cm_waddr = idx;
        cm_wdata = {1'b0, 1'b1, AW'(0)};
      end
      S_SEED: begin
        if (start_ok) begin
          ls_we = 1'b1;
          ls_waddr = '0;
          ls_wdata = AW'(cfg.start);
          cm_we = 1'b1;
          cm_waddr = AW'(cfg.start);
          cm_wdata = {cfg.mode == MODE_BFS, 1'b0, AW'(cfg.start)};
        end
      end
      S_POPW: begin
        cm_raddr = ls_rdata;
      end
      S_DFSV: begin
        if (!cm_rdata[CMW-1]) begin
          cm_we = 1'b1;
          cm_wdata = {1'b1, cm_rdata[AW:0]};
        end
      end
      S_EVAL: begin
        rem_start = (cur_w != CMP_W'(cfg.goal));
      end
      S_NRD: begin
        cm_raddr = nb_addr;
      end
      S_NCHK: begin
        if (nb_take) begin
          cm_waddr = nx;
          if (cfg.mode == MODE_BFS) begin
            cm_we = 1'b1;
            cm_wdata = {1'b1, 1'b0, cur};
          end else begin
            cm_we = cm_rdata[AW];
            cm_wdata = {1'b0, 1'b0, cur};
          end
          ls_we = (tail < LW'(LIST_DEPTH));
        end
      end
      S_TRD: begin
        pt_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      head <= '0;
      tail <= '0;
      visit <= '0;
      ptotal <= '0;
      status <= ST_FAILED;
      dup <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          idx <= idx + AW'(1);
          if (idx == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            dup <= 1'b0;
            res_cell <= '0;
            unique case (item.command)
              CMD_WALL: state <= S_DONE;
              CMD_RESTART: begin
                head <= '0;
                tail <= '0;
                ptotal <= '0;
                visit <= '0;
                idx <= '0;
                state <= S_CLR;
              end
              CMD_STEP: begin
                if (status != ST_SEARCH) begin
                  state <= S_DONE;
                end else if (head >= tail) begin
                  status <= ST_FAILED;
                  state <= S_DONE;
                end else begin
                  if (cfg.mode == MODE_BFS) begin
                    head <= head + LW'(1);
                    visit <= visit + CNT_W'(1);
                  end else begin
                    tail <= tail - LW'(1);
                  end
                  state <= S_POPW;
                end
              end
              default: begin
                if (CMP_W'(item.path_position) < CMP_W'(ptotal)) begin
                  state <= S_PW;
                end else begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_CLR: begin
          idx <= idx + AW'(1);
          if (idx == AW'(CELLS - 1)) begin
            state <= S_SEED;
          end
        end
        S_SEED: begin
          if (start_ok) begin
            status <= ST_SEARCH;
            tail <= LW'(1);
          end else begin
            status <= ST_FAILED;
          end
          state <= S_DONE;
        end
        S_POPW: begin
          cur <= ls_rdata;
          res_cell <= CELL_W'(ls_rdata);
          state <= (cfg.mode == MODE_DFS) ? S_DFSV : S_EVAL;
        end
        S_DFSV: begin
          if (cm_rdata[CMW-1]) begin
            dup <= 1'b1;
            state <= S_DONE;
          end else begin
            visit <= visit + CNT_W'(1);
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (cur_w == CMP_W'(cfg.goal)) begin
            status <= ST_FOUND;
            tlen <= '0;
            state <= S_TRD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_done) begin
            exist[0] <= cur_w >= CMP_W'(cfg.cols);
            exist[1] <= cur_w + CMP_W'(cfg.cols) < cfg.n;
            exist[2] <= rem != '0;
            exist[3] <= {1'b0, rem} + (DIM_W+1)'(1) < {1'b0, cfg.cols};
            slot_cnt <= '0;
            state <= S_NRD;
          end
        end
        S_NRD: begin
          if (exist[slot]) begin
            nx <= nb_addr;
            state <= S_NCHK;
          end else if (slot_cnt == 2'd3) begin
            state <= S_DONE;
          end else begin
            slot_cnt <= slot_cnt + 2'd1;
          end
        end
        S_NCHK: begin
          if (nb_take && tail < LW'(LIST_DEPTH)) begin
            tail <= tail + LW'(1);
          end
          if (slot_cnt == 2'd3) begin
            state <= S_DONE;
          end else begin
            slot_cnt <= slot_cnt + 2'd1;
            state <= S_NRD;
          end
        end
        S_TRD: begin
          state <= S_TCHK;
        end
        S_TCHK: begin
          if (trace_end) begin
            ptotal <= tlen + PW'(1);
            state <= S_DONE;
          end else begin
            cur <= cm_rdata[AW-1:0];
            tlen <= tlen + PW'(1);
            state <= S_TRD;
          end
        end
        S_PW: begin
          res_cell <= CELL_W'(pt_rdata);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.cell_res = res_cell;
  assign res.status = status;
  assign res.visited_total = visit;
  assign res.path_cells = CNT_W'(ptotal);
  assign res.duplicate_skip = dup;

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= LW'(LIST_DEPTH)) else $error("work list tail past depth");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail) else $error("work list head passed tail");

  a_found_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && status == ST_FOUND) |-> ptotal != '0)
    else $error("goal reached without a stored path");

  a_dup_dfs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && dup) |-> cfg.mode == MODE_DFS)
    else $error("duplicate skip outside depth-first mode");

endmodule

>>> design/grid_path_search_bfs_dfs.sv
`timescale 1ns / 1ps
// channel  dir  fields                                                     accepted when
// item     in   command, cell_index, wall_bit, path_position               valid && ready
// result   out  cell_res, status, visited_total, path_cells, duplicate_skip valid && ready
// cfg      in   index, data                                                valid && ready
//
// after reset all MAX_ROWS*MAX_COLUMNS wall map cells are swept clear, one cell a cycle
// restart sweeps the visited/parent memory the same way, then seeds the start cell
// a step pops a cell and tests it for the goal (in depth-first after a visited check), then
// takes the column remainder at one bit a cycle, then reads and checks each neighbor inside
// the grid and skips each missing one; reaching the goal skips the remainder and walks the
// parents to store the path; one result is held while the next item is taken
module grid_path_search_bfs_dfs import gps_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLUMNS = 32,
  parameter int LIST_DEPTH = 4100
) (
  input logic       clk,
  input logic       rst,
  gps_in_if.sink    item,
  gps_out_if.source result,
  gps_cfg_if.sink   cfg
);

  logic [REG_DIM_W-1:0] row_count, column_count;
  logic [CELL_W-1:0]    start_cell, goal_cell;
  logic                 search_mode;
  logic [DIM_W-1:0]     rows_used, cols_used;
  logic [CMP_W-1:0]     cell_total;
  cfg_t                 cfg_s;
  item_t                item_s;
  res_t                 res_s, res_q;
  logic                 seq_idle, seq_valid, take, out_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= REG_DIM_W'(25);
      column_count <= REG_DIM_W'(25);
      start_cell <= CELL_W'(26);
      goal_cell <= CELL_W'(598);
      search_mode <= MODE_BFS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ROWS:  row_count <= cfg.data[REG_DIM_W-1:0];
        CFG_COLS:  column_count <= cfg.data[REG_DIM_W-1:0];
        CFG_START: start_cell <= cfg.data;
        CFG_GOAL:  goal_cell <= cfg.data;
        CFG_MODE:  search_mode <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // grid size clamped to 1..max
  always_comb begin
    rows_used = DIM_W'(row_count);
    if (row_count == '0) rows_used = DIM_W'(1);
    else if (DIM_W'(row_count) > DIM_W'(MAX_ROWS)) rows_used = DIM_W'(MAX_ROWS);
    cols_used = DIM_W'(column_count);
    if (column_count == '0) cols_used = DIM_W'(1);
    else if (DIM_W'(column_count) > DIM_W'(MAX_COLUMNS)) cols_used = DIM_W'(MAX_COLUMNS);
  end

  always_ff @(posedge clk) begin
    cell_total <= CMP_W'(rows_used) * CMP_W'(cols_used);
  end

  assign cfg_s.rows = rows_used;
  assign cfg_s.cols = cols_used;
  assign cfg_s.n = cell_total;
  assign cfg_s.start = start_cell;
  assign cfg_s.goal = goal_cell;
  assign cfg_s.mode = search_mode;

  assign item_s.command = item.command;
  assign item_s.cell_index = item.cell_index;
  assign item_s.wall_bit = item.wall_bit;
  assign item_s.path_position = item.path_position;

  assign item.ready = seq_idle;
  assign take = seq_valid && (!out_valid || result.ready);

  gps_seq #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .LIST_DEPTH(LIST_DEPTH)) u_seq (
    .clk, .rst, .cfg(cfg_s), .item(item_s), .accept(item.valid && item.ready),
    .idle(seq_idle), .res_valid(seq_valid), .res_take(take), .res(res_s));

  // output register frees the sequencer while a beat waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_s;
    end
  end

  assign result.valid = out_valid;
  assign result.cell_res = res_q.cell_res;
  assign result.status = res_q.status;
  assign result.visited_total = res_q.visited_total;
  assign result.path_cells = res_q.path_cells;
  assign result.duplicate_skip = res_q.duplicate_skip;

endmodule
